// ===== rtl/spol_pkg.sv =====
// Shared types for the sorted priority order list.
// Holds request codes, per-cell commands and the link/control structs.
// No dependencies.
package spol_pkg;

  localparam int unsigned KeyW    = 8;
  localparam int unsigned HandleW = 16;
  localparam int unsigned CountW  = 6;

  // Request codes carried in s_axis_tuser
  typedef enum logic [2:0] {
    REQ_INSERT = 3'd0,
    REQ_START  = 3'd1,
    REQ_NEXT   = 3'd2,
    REQ_QUERY  = 3'd3,
    REQ_CLEAR  = 3'd4
  } req_e;

  // Command broadcast to every cell
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_START,
    CELL_NEXT,
    CELL_CLEAR
  } cell_op_e;

  typedef struct packed {
    cell_op_e             op;
    logic [KeyW-1:0]      key;
    logic [HandleW-1:0]   handle;
  } spol_ctrl_t;

  // What one cell hands to its right neighbor
  typedef struct packed {
    logic                 lt;      // new key sorts behind this cell
    logic [KeyW-1:0]      key;
    logic [HandleW-1:0]   handle;
    logic                 nxt;     // next cursor sits here
    logic                 cur;     // current cursor sits here
  } spol_link_t;

endpackage

// ===== rtl/spol_cell.sv =====
// One slot of the sorted list: key, handle and the two cursor marks.
// Shifts right on insert and passes the next mark to its neighbor.
// Depends on spol_pkg.
module spol_cell import spol_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  spol_ctrl_t ctrl_i,
  input  logic       head_i,   // first slot of the row
  input  logic       occ_i,    // slot holds a live entry
  input  spol_link_t left_i,
  output spol_link_t right_o
);

  logic [KeyW-1:0]    key_q, key_d;
  logic [HandleW-1:0] handle_q, handle_d;
  logic               nxt_q, nxt_d;
  logic               cur_q, cur_d;
  logic               lt;

  // Ordering compare against the incoming key
  assign lt = occ_i && ($signed(ctrl_i.key) < $signed(key_q));

  assign right_o.lt     = lt;
  assign right_o.key    = key_q;
  assign right_o.handle = handle_q;
  assign right_o.nxt    = nxt_q;
  assign right_o.cur    = cur_q;

  // Next-state selection
  always_comb begin
    key_d    = key_q;
    handle_d = handle_q;
    nxt_d    = nxt_q;
    cur_d    = cur_q;
    unique case (ctrl_i.op)
      CELL_INSERT: begin
        if (!lt) begin
          if (left_i.lt) begin
            // insertion point: new entry, no cursor marks
            key_d    = ctrl_i.key;
            handle_d = ctrl_i.handle;
            nxt_d    = 1'b0;
            cur_d    = 1'b0;
          end else begin
            // behind the insertion point: take neighbor's entry and marks
            key_d    = left_i.key;
            handle_d = left_i.handle;
            nxt_d    = left_i.nxt;
            cur_d    = left_i.cur;
          end
        end
      end
      // round start: only a live head slot gets the next mark
      CELL_START: nxt_d = head_i & occ_i;
      CELL_NEXT: begin
        cur_d = nxt_q;
        nxt_d = left_i.nxt & occ_i;
      end
      CELL_CLEAR: begin
        nxt_d = 1'b0;
        cur_d = 1'b0;
      end
      default: ;
    endcase
  end

  // Entry payload, no reset
  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    handle_q <= handle_d;
  end

  // Cursor marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nxt_q <= 1'b0;
      cur_q <= 1'b0;
    end else begin
      nxt_q <= nxt_d;
      cur_q <= cur_d;
    end
  end

endmodule

// ===== rtl/sorted_priority_order_list.sv =====
// Sorted priority order list: a row of MAX_ENTRIES cells kept in descending
// signed key order. Requests (insert, start round, take next, query current,
// clear) arrive on the s_axis channel, the kind in tuser and handle/key in
// tdata. Every request yields exactly one result transaction on m_axis.
// All cells compare the new key in parallel and shift toward the
// tail in the same edge, and the cursors are marks in the cells that
// move with their entries. The result is registered, so it appears in
// the cycle after acceptance, and a new request is taken every
// cycle while the output register is empty or being drained.
// When the receiver stalls, the result holds in the output register and
// s_axis_tready drops until it is taken.
// Reset empties the list and clears both cursors; entry contents are not
// cleared, since only live slots are ever read.
// Depends on spol_pkg and spol_cell.
module sorted_priority_order_list import spol_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [15:0] entry_handle, [23:16] order_key
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [15:0] result_handle, [21:16] entry_count
  output logic [1:0]  m_axis_tuser_o    // [0] result_valid, [1] insert_dropped
);

  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  logic               accept;
  logic               full;
  spol_ctrl_t         ctrl;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [MAX_ENTRIES-1:0] occ;
  spol_link_t         link [MAX_ENTRIES+1];
  logic [MAX_ENTRIES-1:0] nxt_vec, cur_vec;

  logic [HandleW-1:0] nxt_handle, cur_handle;
  logic [HandleW-1:0] res_handle;
  logic               res_valid, res_dropped;

  logic               out_valid_q;
  logic [23:0]        out_data_q;
  logic [1:0]         out_user_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign full            = (cnt_q == CW'(MAX_ENTRIES));

  // Request decode and count update
  always_comb begin
    ctrl.op     = CELL_HOLD;
    ctrl.key    = s_axis_tdata_i[23:16];
    ctrl.handle = s_axis_tdata_i[15:0];
    cnt_d       = cnt_q;
    res_handle  = '0;
    res_valid   = 1'b0;
    res_dropped = 1'b0;
    if (accept) begin
      unique case (s_axis_tuser_i)
        REQ_INSERT: begin
          if (full) begin
            res_dropped = 1'b1;
          end else begin
            ctrl.op = CELL_INSERT;
            cnt_d   = cnt_q + CW'(1);
          end
        end
        REQ_START: ctrl.op = CELL_START;
        REQ_NEXT: begin
          ctrl.op    = CELL_NEXT;
          res_handle = nxt_handle;
          res_valid  = |nxt_vec;
        end
        REQ_QUERY: begin
          res_handle = cur_handle;
          res_valid  = |cur_vec;
        end
        REQ_CLEAR: begin
          ctrl.op = CELL_CLEAR;
          cnt_d   = '0;
        end
        default: ;
      endcase
    end
  end

  // Head of the chain: virtual slot ahead of cell 0, never holds a mark
  always_comb begin
    link[0].lt     = 1'b1;
    link[0].key    = '0;
    link[0].handle = '0;
    link[0].nxt    = 1'b0;
    link[0].cur    = 1'b0;
  end

  // Cell row
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    assign occ[i]     = (CW'(i) < cnt_q);
    assign nxt_vec[i] = link[i+1].nxt;
    assign cur_vec[i] = link[i+1].cur;
    spol_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .head_i (i == 0),
      .occ_i  (occ[i]),
      .left_i (link[i]),
      .right_o(link[i+1])
    );
  end

  // One-hot cursor read: AND-OR over the cells
  always_comb begin
    nxt_handle = '0;
    cur_handle = '0;
    for (int unsigned i = 0; i < MAX_ENTRIES; i++) begin
      nxt_handle = nxt_handle | (link[i+1].handle & {HandleW{nxt_vec[i]}});
      cur_handle = cur_handle | (link[i+1].handle & {HandleW{cur_vec[i]}});
    end
  end

  // Entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {2'b00, CountW'(cnt_d), res_handle};
      out_user_q <= {res_dropped, res_valid};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  // Checks
  a_cur_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cur_vec)) else $error("more than one current entry");

  a_nxt_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(nxt_vec)) else $error("more than one next entry");

  a_nxt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nxt_vec & ~occ) == '0) else $error("next cursor past the tail");

  a_cur_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_vec & ~occ) == '0) else $error("current cursor past the tail");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_ENTRIES)) else $error("entry count overflow");

endmodule
